>>> src/ctc_pkg.sv
package ctc_pkg;

  localparam int MAX_WORD_DEF = 127;
  localparam int QDEPTH_DEF   = 2;
  localparam int NUM_KW       = 16;

  typedef enum logic [2:0] {
    KIND_RESERVED = 3'd0,
    KIND_INTEGER  = 3'd1,
    KIND_FLOAT    = 3'd2,
    KIND_OPERATOR = 3'd3,
    KIND_IDENT    = 3'd4,
    KIND_STMT_END = 3'd5,
    KIND_ERROR    = 3'd6
  } kind_t;

  // One queue entry describes every result that one input character causes.
  typedef struct packed {
    logic  has_word;
    kind_t kind;
    logic  has_stmt;
    logic  err;
  } q_entry_t;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Keyword text is right-justified: the last character sits in the low byte.
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    "const", "int", "float", "double", "long", "static", "void", "char",
    "extern", "return", "break", "enum", "struct", "typedef", "union", "goto"
  };

  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd5, 4'd3, 4'd5, 4'd6, 4'd4, 4'd6, 4'd4, 4'd4,
    4'd6, 4'd6, 4'd5, 4'd4, 4'd6, 4'd7, 4'd5, 4'd4
  };

  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] p);
    logic [63:0] w;
    logic [2:0]  sh;
    w  = KW_TEXT[k];
    sh = 3'(KW_LEN[k] - 4'd1 - {1'b0, p});
    return w[{sh, 3'b000} +: 8];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return (c == CH_UNDER) || is_digit(c) ||
           ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage

>>> src/ctc_if.sv
interface ctc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, ch, end_of_input, input ready);
  modport sink (input valid, ch, end_of_input, output ready);
endinterface

interface ctc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic       error_seen;
  logic       last;

  modport source (output valid, kind, error_seen, last, input ready);
  modport sink (input valid, kind, error_seen, last, output ready);
endinterface

>>> src/ctc_front.sv
module ctc_front
  import ctc_pkg::*;
#(
  parameter int MAX_WORD = MAX_WORD_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  ctc_in_if.sink   in_ch,
  input  logic     q_full,
  output logic     push,
  output q_entry_t push_entry
);

  localparam int LenW = $clog2(MAX_WORD + 1);
  localparam logic [LenW-1:0] LenMax = LenW'(MAX_WORD);

  logic [LenW-1:0]   len_r, len_nxt;
  logic [NUM_KW-1:0] hits_r, hits_nxt;
  logic [15:0]       ftc_r, ftc_nxt;
  logic              all_dig_r, all_dig_nxt;
  logic [1:0]        dots_r, dots_nxt;
  logic              fid_r, fid_nxt;
  logic              all_id_r, all_id_nxt;
  logic              sticky_r, sticky_nxt;

  logic              acc;
  logic [7:0]        c;
  logic              delim;
  logic              stmt;
  logic              has_word;
  logic [NUM_KW-1:0] len_match;
  logic              rsv;
  logic              op;
  logic [7:0]        ca;
  logic [7:0]        cb;
  kind_t             kind;

  assign in_ch.ready = !q_full;

  always_comb begin
    acc   = in_ch.valid && in_ch.ready;
    c     = in_ch.ch;
    delim = in_ch.end_of_input || is_space(c) || (c == CH_SEMI);
    stmt  = !in_ch.end_of_input && (c == CH_SEMI);
    has_word = (len_r != '0);

    for (int k = 0; k < NUM_KW; k++) begin
      len_match[k] = (len_r == LenW'(KW_LEN[k]));
    end
    rsv = |(hits_r & len_match);
    ca  = ftc_r[7:0];
    cb  = ftc_r[15:8];
    op  = ((len_r == LenW'(1)) &&
           ((ca == CH_PLUS) || (ca == CH_MINUS) || (ca == CH_STAR) || (ca == CH_SLASH) ||
            (ca == CH_EQ) || (ca == CH_GT) || (ca == CH_LT))) ||
          ((len_r == LenW'(2)) && (cb == CH_EQ) &&
           ((ca == CH_EQ) || (ca == CH_BANG) || (ca == CH_GT) || (ca == CH_LT)));

    if (rsv) begin
      kind = KIND_RESERVED;
    end else if (op) begin
      kind = KIND_OPERATOR;
    end else if (all_dig_r && (dots_r == 2'd0)) begin
      kind = KIND_INTEGER;
    end else if (all_dig_r && (dots_r == 2'd1)) begin
      kind = KIND_FLOAT;
    end else if (!fid_r && all_id_r) begin
      kind = KIND_IDENT;
    end else begin
      kind = KIND_ERROR;
    end

    sticky_nxt = sticky_r | (acc && delim && has_word && (kind == KIND_ERROR));
    push       = acc && delim && (has_word || stmt);
    push_entry = '{has_word: has_word, kind: kind, has_stmt: stmt, err: sticky_nxt};

    for (int k = 0; k < NUM_KW; k++) begin
      hits_nxt[k] = hits_r[k] && (len_r < LenW'(KW_LEN[k])) &&
                    (kw_char(4'(k), len_r[2:0]) == c);
    end

    ftc_nxt = ftc_r;
    if (len_r == '0) begin
      ftc_nxt = {ftc_r[15:8], c};
    end else if (len_r == LenW'(1)) begin
      ftc_nxt = {c, ftc_r[7:0]};
    end

    fid_nxt = (len_r == '0) ? is_digit(c) : fid_r;

    dots_nxt    = dots_r;
    all_dig_nxt = all_dig_r;
    if (c == CH_DOT) begin
      if (dots_r != 2'd2) begin
        dots_nxt = dots_r + 2'd1;
      end
    end else if (!is_digit(c)) begin
      all_dig_nxt = 1'b0;
    end

    all_id_nxt = all_id_r && is_ident(c);
    len_nxt    = (len_r != LenMax) ? len_r + LenW'(1) : len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      hits_r    <= '1;
      ftc_r     <= '0;
      all_dig_r <= 1'b1;
      dots_r    <= 2'd0;
      fid_r     <= 1'b0;
      all_id_r  <= 1'b1;
      sticky_r  <= 1'b0;
    end else begin
      sticky_r <= sticky_nxt;
      if (acc) begin
        if (delim) begin
          len_r     <= '0;
          hits_r    <= '1;
          ftc_r     <= '0;
          all_dig_r <= 1'b1;
          dots_r    <= 2'd0;
          fid_r     <= 1'b0;
          all_id_r  <= 1'b1;
        end else begin
          len_r     <= len_nxt;
          hits_r    <= hits_nxt;
          ftc_r     <= ftc_nxt;
          all_dig_r <= all_dig_nxt;
          dots_r    <= dots_nxt;
          fid_r     <= fid_nxt;
          all_id_r  <= all_id_nxt;
        end
      end
    end
  end

endmodule

>>> src/ctc_fifo.sv
module ctc_fifo
  import ctc_pkg::*;
#(
  parameter int DEPTH = QDEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  output logic     q_valid,
  output q_entry_t q_entry,
  input  logic     pop
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

  q_entry_t        mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] cnt_r;

  assign full    = (cnt_r == CntW'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CntW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("Queue written while full.");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("Queue read while empty.");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(DEPTH))
    else $error("Queue count exceeds depth.");
`endif

endmodule

>>> src/ctc_back.sv
module ctc_back
  import ctc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  q_entry_t  q_entry,
  output logic      pop,
  ctc_out_if.source out_res
);

  logic  out_vld_r, out_vld_nxt;
  kind_t kind_r, kind_nxt;
  logic  err_r, err_nxt;
  logic  last_r, last_nxt;
  logic  pend_r, pend_nxt;
  logic  can_load;

  assign out_res.valid      = out_vld_r;
  assign out_res.kind       = kind_r;
  assign out_res.error_seen = err_r;
  assign out_res.last       = last_r;

  always_comb begin
    can_load    = !out_vld_r || out_res.ready;
    pop         = can_load && !pend_r && q_valid;
    out_vld_nxt = out_vld_r;
    kind_nxt    = kind_r;
    err_nxt     = err_r;
    last_nxt    = last_r;
    pend_nxt    = pend_r;
    if (can_load) begin
      if (pend_r) begin
        out_vld_nxt = 1'b1;
        kind_nxt    = KIND_STMT_END;
        last_nxt    = 1'b1;
        pend_nxt    = 1'b0;
      end else if (q_valid) begin
        out_vld_nxt = 1'b1;
        err_nxt     = q_entry.err;
        if (q_entry.has_word) begin
          kind_nxt = q_entry.kind;
          last_nxt = !q_entry.has_stmt;
          pend_nxt = q_entry.has_stmt;
        end else begin
          kind_nxt = KIND_STMT_END;
          last_nxt = 1'b1;
          pend_nxt = 1'b0;
        end
      end else begin
        out_vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      pend_r    <= pend_nxt;
    end
    kind_r <= kind_nxt;
    err_r  <= err_nxt;
    last_r <= last_nxt;
  end

`ifndef SYNTHESIS
  a_pend_held: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (out_vld_r && !last_r))
    else $error("Pending statement end without a word result in flight.");

  a_stmt_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !last_r) |-> (kind_r != KIND_STMT_END))
    else $error("Statement end shown as a non-final result.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_res.ready) |=>
      (out_vld_r && $stable(kind_r) && $stable(err_r) && $stable(last_r)))
    else $error("Result changed while waiting for its transfer.");
`endif

endmodule

>>> src/c_token_classifier.sv
// Streaming token classifier: one character per transfer on in_chan, and zero, one or
// two results on out_chan for each character that ends a word (whitespace, semicolon
// or end of input); a semicolon adds a statement-end result after any pending word.
// The front stage updates registered per-word flags and accepts a character every
// cycle while the result queue (Q_DEPTH entries, two by default) has room; the back
// stage shows one result per cycle from its output register while out_chan is ready,
// so a word followed by a semicolon gives two results from one queue entry. The first
// result of a character goes through the queue and then the output register.
module c_token_classifier
  import ctc_pkg::*;
#(
  parameter int MAX_WORD = MAX_WORD_DEF,
  parameter int Q_DEPTH  = QDEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ctc_in_if.sink    in_chan,
  ctc_out_if.source out_chan
);

  logic     push;
  q_entry_t push_entry;
  logic     q_full;
  logic     q_valid;
  q_entry_t q_entry;
  logic     pop;

  ctc_front #(.MAX_WORD(MAX_WORD)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_chan),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  ctc_fifo #(.DEPTH(Q_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (pop)
  );

  ctc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .pop     (pop),
    .out_res (out_chan)
  );

endmodule

>>> test/ctc_checker.sv
module ctc_checker
  import ctc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_end_of_input,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] out_kind,
  input  logic       out_error_seen,
  input  logic       out_last,
  output int         fail_count,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_t kind;
    logic  error_seen;
    logic  last;
  } token_result_t;

  localparam int WORD_LEN_MAX = 127;

  string reserved_words [16] = '{
    "const", "int", "float", "double", "long", "static", "void", "char",
    "extern", "return", "break", "enum", "struct", "typedef", "union", "goto"
  };

  token_result_t expected_tokens [$];
  int            fails = 0;

  logic [6:0]  word_len;
  logic [15:0] kw_alive;
  logic [7:0]  first_ch;
  logic [7:0]  second_ch;
  logic        digits_only;
  logic [1:0]  dots;
  logic        starts_with_digit;
  logic        ident_only;
  logic        sticky_err;

  function automatic logic digit_ch(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic name_ch(input logic [7:0] c);
    return c == CH_UNDER || digit_ch(c) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic blank_ch(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
  endfunction

  function automatic void clear_word();
    word_len          = '0;
    kw_alive          = '1;
    first_ch          = '0;
    second_ch         = '0;
    digits_only       = 1'b1;
    dots              = '0;
    starts_with_digit = 1'b0;
    ident_only        = 1'b1;
  endfunction

  function automatic kind_t word_kind();
    for (int k = 0; k < 16; k++) begin
      if (kw_alive[k] && reserved_words[k].len() == int'(word_len)) return KIND_RESERVED;
    end
    if (word_len == 7'd1 &&
        first_ch inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQ, CH_GT, CH_LT}) begin
      return KIND_OPERATOR;
    end
    if (word_len == 7'd2 && second_ch == CH_EQ &&
        first_ch inside {CH_EQ, CH_BANG, CH_GT, CH_LT}) begin
      return KIND_OPERATOR;
    end
    if (digits_only && dots == 2'd0) return KIND_INTEGER;
    if (digits_only && dots == 2'd1) return KIND_FLOAT;
    if (!starts_with_digit && ident_only) return KIND_IDENT;
    return KIND_ERROR;
  endfunction

  function automatic void grow_word(input logic [7:0] c);
    int pos;
    pos = int'(word_len);
    if (pos == 0) begin
      starts_with_digit = digit_ch(c);
      first_ch = c;
    end else if (pos == 1) begin
      second_ch = c;
    end
    for (int k = 0; k < 16; k++) begin
      if (kw_alive[k] && (pos >= reserved_words[k].len() || reserved_words[k][pos] != c)) begin
        kw_alive[k] = 1'b0;
      end
    end
    if (c == CH_DOT) begin
      if (dots != 2'd2) dots = dots + 2'd1;
    end else if (!digit_ch(c)) begin
      digits_only = 1'b0;
    end
    if (!name_ch(c)) ident_only = 1'b0;
    if (pos < WORD_LEN_MAX) word_len = word_len + 7'd1;
  endfunction

  function automatic void take_char(input logic [7:0] c, input logic eoi);
    kind_t kinds [$];
    if (eoi || blank_ch(c) || c == CH_SEMI) begin
      if (word_len != 7'd0) begin
        kinds.push_back(word_kind());
        if (kinds[0] == KIND_ERROR) sticky_err = 1'b1;
      end
      clear_word();
      if (!eoi && c == CH_SEMI) kinds.push_back(KIND_STMT_END);
      foreach (kinds[i]) begin
        expected_tokens.push_back('{kind: kinds[i], error_seen: sticky_err,
                                    last: (i == kinds.size() - 1)});
      end
    end else begin
      grow_word(c);
    end
  endfunction

  always @(posedge clk) begin : watch
    token_result_t want;
    if (!rst_n) begin
      clear_word();
      sticky_err = 1'b0;
      expected_tokens.delete();
    end else begin
      if (in_valid && in_ready) take_char(in_ch, in_end_of_input);
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected result transfer: kind %0d", out_kind);
          fails++;
        end else begin
          want = expected_tokens.pop_front();
          if (out_kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_kind);
            fails++;
          end
          if (out_error_seen !== want.error_seen) begin
            $error("error_seen: expected %0b, got %0b", want.error_seen, out_error_seen);
            fails++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_last);
            fails++;
          end
        end
      end
    end
    fail_count  <= fails;
    outstanding <= expected_tokens.size();
  end

endmodule

>>> test/tb_c_token_classifier.sv
module tb_c_token_classifier;
  timeunit 1ns;
  timeprecision 1ps;
  import ctc_pkg::*;

  logic clk;
  logic rst_n;

  ctc_in_if  in_chan ();
  ctc_out_if out_chan ();

  int mismatches;
  int results_due;
  int send_idle_pct = 9;
  int recv_idle_pct = 74;
  int items_sent    = 0;

  string keyword_list [16] = '{
    "const", "int", "float", "double", "long", "static", "void", "char",
    "extern", "return", "break", "enum", "struct", "typedef", "union", "goto"
  };
  string operator_list [15] = '{
    "+", "-", "*", "/", "=", "==", "!=", ">=", "<=", ">", "<", "!", "=>", "+=", "=<"
  };
  logic [7:0] blanks [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

  c_token_classifier DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  ctc_checker token_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_chan.valid),
    .in_ready        (in_chan.ready),
    .in_ch           (in_chan.ch),
    .in_end_of_input (in_chan.end_of_input),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_kind        (out_chan.kind),
    .out_error_seen  (out_chan.error_seen),
    .out_last        (out_chan.last),
    .fail_count      (mismatches),
    .outstanding     (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

  function automatic logic [7:0] digit_char();
    return 8'(8'h30 + $urandom_range(9));
  endfunction

  function automatic logic [7:0] ident_char();
    case ($urandom_range(3))
      0: return 8'(8'h61 + $urandom_range(25));
      1: return 8'(8'h41 + $urandom_range(25));
      2: return digit_char();
      default: return CH_UNDER;
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid        <= 1'b0;
      in_chan.ch           <= 8'($urandom);
      in_chan.end_of_input <= 1'($urandom);
      @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.ch           <= c;
    in_chan.end_of_input <= eoi;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  // Holds the input off until every predicted result has been transferred.
  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic send_digits(input int n);
    for (int i = 0; i < n; i++) send_char(digit_char(), 1'b0);
  endtask

  task automatic send_token();
    int    pick;
    int    n;
    string w;
    pick = $urandom_range(99);
    if (pick < 15) begin
      w = keyword_list[$urandom_range(15)];
      case ($urandom_range(2))
        0: send_text(w);
        1: begin
          n = $urandom_range(1, w.len());
          for (int i = 0; i < n; i++) send_char(w[i], 1'b0);
        end
        default: begin
          send_text(w);
          send_char(ident_char(), 1'b0);
        end
      endcase
    end else if (pick < 30) begin
      send_text(operator_list[$urandom_range(14)]);
    end else if (pick < 45) begin
      send_digits($urandom_range(1, 6));
    end else if (pick < 58) begin
      send_digits($urandom_range(0, 4));
      send_char(CH_DOT, 1'b0);
      send_digits($urandom_range(0, 4));
      if ($urandom_range(4) == 0) begin
        send_char(CH_DOT, 1'b0);
        send_digits($urandom_range(0, 2));
      end
    end else if (pick < 76) begin
      case ($urandom_range(4))
        0, 4: send_char(8'(8'h61 + $urandom_range(25)), 1'b0);
        1: send_char(8'(8'h41 + $urandom_range(25)), 1'b0);
        2: send_char(CH_UNDER, 1'b0);
        default: send_char(digit_char(), 1'b0);
      endcase
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) send_char(ident_char(), 1'b0);
    end else if (pick < 88) begin
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) begin
        send_char($urandom_range(1) ? ident_char() : 8'($urandom_range(255)), 1'b0);
      end
    end else if (pick < 91) begin
      n = $urandom_range(120, 140);
      if ($urandom_range(2) == 0) begin
        send_digits(n);
      end else begin
        for (int i = 0; i < n; i++) send_char(ident_char(), 1'b0);
      end
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) send_char(8'($urandom_range(255)), 1'b0);
    end

    pick = $urandom_range(99);
    if (pick < 60) begin
      send_char(blanks[$urandom_range(5)], 1'b0);
    end else if (pick < 85) begin
      send_char(CH_SEMI, 1'b0);
    end else if (pick < 90) begin
      n = $urandom_range(2, 4);
      for (int i = 0; i < n; i++) send_char(CH_SEMI, 1'b0);
    end else if (pick >= 95) begin
      send_char(8'($urandom_range(255)), 1'b1);
    end
  endtask

  initial begin
    int phase_end;
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.ch           <= '0;
    in_chan.end_of_input <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("int 1.5");
    send_char(CH_TAB, 1'b0);
    send_text("==");
    send_char(CH_LF, 1'b0);
    send_text("_9;;7");
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(CH_CR, 1'b0);
    send_text("42");
    send_char(CH_FF, 1'b0);
    send_char(CH_DOT, 1'b0);
    send_char(8'hA5, 1'b1);
    send_char(CH_SEMI, 1'b1);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_end = items_sent + 475;
      while (items_sent < phase_end) send_token();
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
